### rtl/kmct_pkg.sv
// Shared types, constants and the note frequency table of the key matrix tone block.
`default_nettype none

package kmct_pkg;

  // Widths of the transaction fields.
  localparam int unsigned ROW_W    = 2;
  localparam int unsigned LEVELS_W = 8;
  localparam int unsigned KEY_W    = 5;
  localparam int unsigned FREQ_W   = 10;

  // Row numbers the row field can carry, and notes in the table.
  localparam int unsigned ROW_SLOTS  = 1 << ROW_W;
  localparam int unsigned NOTE_COUNT = 32;

  // One accepted row after change detection: which columns changed and to what.
  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [LEVELS_W-1:0] levels;
    logic [LEVELS_W-1:0] changed;
  } item_t;

  // Fixed note frequency of each key, in hertz.
  function automatic logic [FREQ_W-1:0] note_hz(input logic [KEY_W-1:0] key);
    logic [FREQ_W-1:0] hz;
    case (key)
      5'd0:    hz = 10'd87;
      5'd1:    hz = 10'd92;
      5'd2:    hz = 10'd98;
      5'd3:    hz = 10'd104;
      5'd4:    hz = 10'd110;
      5'd5:    hz = 10'd116;
      5'd6:    hz = 10'd123;
      5'd7:    hz = 10'd131;
      5'd8:    hz = 10'd138;
      5'd9:    hz = 10'd147;
      5'd10:   hz = 10'd155;
      5'd11:   hz = 10'd165;
      5'd12:   hz = 10'd175;
      5'd13:   hz = 10'd185;
      5'd14:   hz = 10'd196;
      5'd15:   hz = 10'd208;
      5'd16:   hz = 10'd220;
      5'd17:   hz = 10'd233;
      5'd18:   hz = 10'd247;
      5'd19:   hz = 10'd262;
      5'd20:   hz = 10'd277;
      5'd21:   hz = 10'd294;
      5'd22:   hz = 10'd311;
      5'd23:   hz = 10'd330;
      5'd24:   hz = 10'd349;
      5'd25:   hz = 10'd370;
      5'd26:   hz = 10'd392;
      5'd27:   hz = 10'd415;
      5'd28:   hz = 10'd440;
      5'd29:   hz = 10'd466;
      5'd30:   hz = 10'd494;
      5'd31:   hz = 10'd523;
      default: hz = 10'd0;
    endcase
    return hz;
  endfunction

endpackage

`default_nettype wire

### rtl/key_matrix_change_to_tone.sv
// Top level of the key matrix change-to-tone block.
// Each input transaction carries one scanned row of the key matrix: its row number and
// the active-low levels of its columns. The block remembers the last level of every key
// (all released after reset) and, for every column of that row whose level changed,
// gives one output transaction in ascending column order. A press starts a tone at the
// key's note frequency (87 Hz to 523 Hz); a release stops all tone with a frequency of
// zero. The final event of a row carries last, and a row without changes gives nothing.
// Rows not below ROWS and columns not below COLS are ignored. Change detection and the
// key level update happen in the cycle a row is accepted, so rows that change at most
// one key may be offered back to back while the output takes events. A row that changes
// n keys, up to eight, hands its n events one at a time through the single event output
// register; the next row is accepted in the cycle the last of those events is loaded.
// The first event of a row passes through the pending row register and then the event
// output register before it is presented.
`default_nettype none

module key_matrix_change_to_tone #(
  parameter int unsigned ROWS = 4,
  parameter int unsigned COLS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [kmct_pkg::ROW_W-1:0]    row_i,
  input  wire logic [kmct_pkg::LEVELS_W-1:0] column_levels_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [kmct_pkg::KEY_W-1:0]         key_index_o,
  output logic                               tone_on_o,
  output logic [kmct_pkg::FREQ_W-1:0]        frequency_hz_o,
  output logic                               last_o
);

  logic            in_accept;
  kmct_pkg::item_t item;

  // A transaction is taken when the pending register will be free at this edge.
  assign in_accept = in_valid_i && in_ready_o;

  // The key level store compares the incoming row with the kept levels and
  // records the new ones as soon as the row is accepted.
  kmct_change #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_change (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .row_i    (row_i),
    .levels_i (column_levels_i),
    .item_o   (item)
  );

  // The serialiser hands the changed columns out one at a time, lowest first.
  kmct_serial #(
    .COLS (COLS)
  ) u_serial (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .item_i         (item),
    .ready_o        (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_index_o    (key_index_o),
    .tone_on_o      (tone_on_o),
    .frequency_hz_o (frequency_hz_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

### rtl/kmct_change.sv
// Key level store and per-row change detection.
`default_nettype none

module kmct_change #(
  parameter int unsigned ROWS = 4,
  parameter int unsigned COLS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [kmct_pkg::ROW_W-1:0]     row_i,
  input  wire logic [kmct_pkg::LEVELS_W-1:0]  levels_i,
  output kmct_pkg::item_t                     item_o
);

  localparam int unsigned NCol = (COLS < kmct_pkg::LEVELS_W) ? COLS : kmct_pkg::LEVELS_W;
  localparam logic [kmct_pkg::LEVELS_W-1:0] ColMask =
    kmct_pkg::LEVELS_W'((33'd1 << NCol) - 33'd1);

  logic [kmct_pkg::ROW_SLOTS-1:0][kmct_pkg::LEVELS_W-1:0] key_levels_q, key_levels_d;
  logic                                                    row_ok;
  logic [kmct_pkg::LEVELS_W-1:0]                           changed;

  // Rows outside the matrix are ignored altogether.
  assign row_ok  = (32'(row_i) < ROWS);
  assign changed = (levels_i ^ key_levels_q[row_i]) & ColMask & {kmct_pkg::LEVELS_W{row_ok}};

  assign item_o.row     = row_i;
  assign item_o.levels  = levels_i;
  assign item_o.changed = changed;

  always_comb begin
    key_levels_d = key_levels_q;
    if (accept_i) begin
      key_levels_d[row_i] = key_levels_q[row_i] ^ changed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_levels_q <= '1;
    end else begin
      key_levels_q <= key_levels_d;
    end
  end

endmodule

`default_nettype wire

### rtl/kmct_serial.sv
// Pending row and output registers handing out one key event per cycle unless stalled.
`default_nettype none

module kmct_serial #(
  parameter int unsigned COLS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire kmct_pkg::item_t               item_i,
  output logic                               ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [kmct_pkg::KEY_W-1:0]         key_index_o,
  output logic                               tone_on_o,
  output logic [kmct_pkg::FREQ_W-1:0]        frequency_hz_o,
  output logic                               last_o
);

  localparam int unsigned KeyW = $clog2(kmct_pkg::ROW_SLOTS * COLS);
  localparam int unsigned ExtW = KeyW + kmct_pkg::KEY_W;
  localparam int unsigned ColW = $clog2(kmct_pkg::LEVELS_W);

  // Pending row: the columns still owed an event.
  logic [kmct_pkg::ROW_W-1:0]    row_q, row_d;
  logic [kmct_pkg::LEVELS_W-1:0] levels_q, levels_d;
  logic [kmct_pkg::LEVELS_W-1:0] pend_q, pend_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic [kmct_pkg::KEY_W-1:0]    key_q, key_d;
  logic                          tone_q, tone_d;
  logic [kmct_pkg::FREQ_W-1:0]   freq_q, freq_d;
  logic                          last_q, last_d;

  logic                          out_load;
  logic                          emit;
  logic [kmct_pkg::LEVELS_W-1:0] low_bit;
  logic [kmct_pkg::LEVELS_W-1:0] remain;
  logic [ColW-1:0]               col;
  logic [KeyW-1:0]               key_full;
  logic [ExtW-1:0]               key_ext;

  assign out_load = !out_valid_q || out_ready_i;
  assign emit     = (pend_q != '0) && out_load;
  assign low_bit  = pend_q & (~pend_q + kmct_pkg::LEVELS_W'(1));
  assign remain   = pend_q & ~low_bit;

  // A new row may enter when no event is owed or the last owed event leaves in this cycle.
  assign ready_o  = (pend_q == '0) || (emit && (remain == '0));

  always_comb begin
    col = '0;
    for (int c = 0; c < kmct_pkg::LEVELS_W; c++) begin
      if (low_bit[c]) begin
        col = ColW'(c);
      end
    end
  end

  assign key_full = KeyW'(32'(row_q) * COLS + 32'(col));
  assign key_ext  = ExtW'(key_full);

  always_comb begin
    row_d       = row_q;
    levels_d    = levels_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    key_d       = key_q;
    tone_d      = tone_q;
    freq_d      = freq_q;
    last_d      = last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (emit) begin
      out_valid_d = 1'b1;
      key_d       = key_ext[kmct_pkg::KEY_W-1:0];
      tone_d      = !levels_q[col];
      if (!levels_q[col] && (key_ext < ExtW'(kmct_pkg::NOTE_COUNT))) begin
        freq_d = kmct_pkg::note_hz(key_ext[kmct_pkg::KEY_W-1:0]);
      end else begin
        freq_d = '0;
      end
      last_d = (remain == '0);
      pend_d = remain;
    end

    if (accept_i) begin
      row_d    = item_i.row;
      levels_d = item_i.levels;
      pend_d   = item_i.changed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    levels_q <= levels_d;
    key_q    <= key_d;
    tone_q   <= tone_d;
    freq_q   <= freq_d;
    last_q   <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign key_index_o    = key_q;
  assign tone_on_o      = tone_q;
  assign frequency_hz_o = freq_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

### rtl/kmct_checker.sv
// Port-level assertions for the key matrix change-to-tone block, and their bind.
`default_nettype none

module kmct_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [kmct_pkg::KEY_W-1:0]    key_index_o,
  input wire logic                          tone_on_o,
  input wire logic [kmct_pkg::FREQ_W-1:0]   frequency_hz_o,
  input wire logic                          last_o
);

  // Nothing is offered while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // A press carries a note, a release carries zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tone_on_o == (frequency_hz_o != '0)))
    else $error("tone command and frequency disagree");

  // Note frequencies stay within the table's range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tone_on_o) |-> ((frequency_hz_o >= 10'd87) && (frequency_hz_o <= 10'd523)))
    else $error("frequency outside the note table");

  // A stalled event keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(key_index_o) &&
      $stable(tone_on_o) && $stable(frequency_hz_o) && $stable(last_o)))
    else $error("stalled event changed");

endmodule

bind key_matrix_change_to_tone kmct_checker u_kmct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .key_index_o    (key_index_o),
  .tone_on_o      (tone_on_o),
  .frequency_hz_o (frequency_hz_o),
  .last_o         (last_o)
);

`default_nettype wire

### tb/sv/tb_key_matrix_change_to_tone.sv
// Self-checking testbench for the key matrix change-to-tone block.
`default_nettype none

module tb_key_matrix_change_to_tone;
  timeunit 1ns;
  timeprecision 1ps;

  // One scanned row waiting to be offered to the block.
  typedef struct packed {
    logic [kmct_pkg::ROW_W-1:0]    row;
    logic [kmct_pkg::LEVELS_W-1:0] levels;
  } scan_row_t;

  // One tone event as the block should present it on its output.
  typedef struct packed {
    logic [kmct_pkg::KEY_W-1:0]  key_index;
    logic                        tone_on;
    logic [kmct_pkg::FREQ_W-1:0] frequency_hz;
    logic                        last;
  } tone_event_t;

  // The matrix is 4 rows of 8 columns, so every row and every column is in range.
  localparam int unsigned MATRIX_ROWS = 4;
  localparam int unsigned MATRIX_COLS = 8;
  localparam int unsigned NUM_KEYS    = MATRIX_ROWS * MATRIX_COLS;

  // Note frequency of every key, lowest key first.
  localparam int unsigned NOTE_TABLE [NUM_KEYS] = '{
    87,  92,  98,  104, 110, 116, 123, 131,
    138, 147, 155, 165, 175, 185, 196, 208,
    220, 233, 247, 262, 277, 294, 311, 330,
    349, 370, 392, 415, 440, 466, 494, 523
  };

  // Number of random rows that must change at least one key.
  localparam int unsigned RANDOM_CHANGING_ROWS = 120;
  // The receiver stops taking events for this many cycles once, mid-run.
  localparam int unsigned HOLD_OFF_CYCLES      = 250;
  localparam int unsigned HOLD_OFF_AFTER_ROWS  = 60;
  // Cycles allowed for stray events after the last expected one has arrived.
  localparam int unsigned DRAIN_CYCLES         = 24;

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_ready;
  logic [kmct_pkg::ROW_W-1:0]    row             = '0;
  logic [kmct_pkg::LEVELS_W-1:0] column_levels   = '0;
  logic                          out_valid;
  logic                          out_ready       = 1'b0;
  logic [kmct_pkg::KEY_W-1:0]    key_index;
  logic                          tone_on;
  logic [kmct_pkg::FREQ_W-1:0]   frequency_hz;
  logic                          last;

  // Rows still to be offered, and tone events predicted but not yet seen.
  scan_row_t   scan_rows_pending [$];
  tone_event_t tone_events_due [$];

  // Predicted level of every key, one bit per key, 1 meaning released.
  logic [NUM_KEYS-1:0] key_levels_model = '1;

  // Level of each row as last generated, used to shape the stimulus.
  logic [kmct_pkg::LEVELS_W-1:0] gen_row_levels [MATRIX_ROWS];

  int unsigned rows_accepted  = 0;
  int unsigned mismatch_count = 0;

  // Set for one long stretch to make the block fill up and stall its input.
  logic hold_off = 1'b0;

  key_matrix_change_to_tone #(
    .ROWS (MATRIX_ROWS),
    .COLS (MATRIX_COLS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .row_i           (row),
    .column_levels_i (column_levels),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .key_index_o     (key_index),
    .tone_on_o       (tone_on),
    .frequency_hz_o  (frequency_hz),
    .last_o          (last)
  );

  // A 12 ns clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Reset is held at the start and never asserted again.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Picks an idle length. In a calm stretch there is no idling at all; otherwise
  // most gaps are short and a few are long.
  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Works out the tone events caused by one accepted row and updates the
  // predicted key levels. Columns are visited in ascending order; each column
  // whose level differs from the kept one gives an event. A press carries the
  // key's note, a release carries a stop with zero frequency, and the final
  // event of the row is flagged as last.
  task automatic predict_tone_events(input logic [kmct_pkg::ROW_W-1:0] scan_row,
                                     input logic [kmct_pkg::LEVELS_W-1:0] levels);
    tone_event_t row_events [MATRIX_COLS];
    int unsigned n_events;
    int unsigned key;
    logic        level;
    n_events = 0;
    for (int unsigned col = 0; col < MATRIX_COLS; col++) begin
      key   = scan_row * MATRIX_COLS + col;
      level = levels[col];
      if (level != key_levels_model[key]) begin
        key_levels_model[key]             = level;
        row_events[n_events].key_index    = key[kmct_pkg::KEY_W-1:0];
        row_events[n_events].tone_on      = ~level;
        row_events[n_events].frequency_hz =
          level ? '0 : NOTE_TABLE[key][kmct_pkg::FREQ_W-1:0];
        row_events[n_events].last         = 1'b0;
        n_events++;
      end
    end
    if (n_events > 0) begin
      row_events[n_events-1].last = 1'b1;
    end
    for (int unsigned i = 0; i < n_events; i++) begin
      tone_events_due.push_back(row_events[i]);
    end
  endtask

  // Queues one row for the driver and keeps the generator's view of the row.
  // Returns whether the row changes at least one key.
  function automatic logic queue_scan_row(input logic [kmct_pkg::ROW_W-1:0] scan_row,
                                          input logic [kmct_pkg::LEVELS_W-1:0] levels);
    scan_row_t item;
    logic      changes;
    item.row    = scan_row;
    item.levels = levels;
    changes     = (levels != gen_row_levels[scan_row]);
    gen_row_levels[scan_row] = levels;
    scan_rows_pending.push_back(item);
    return changes;
  endfunction

  // Driver. A row is taken by the block at an edge where valid and ready are
  // both high; the prediction is made at that same edge. Valid is only lowered
  // or the payload changed once the current row has been accepted.
  int unsigned in_gap  = 0;
  logic        in_calm = 1'b0;

  always @(posedge clk or negedge rst_n) begin
    logic      accepted;
    scan_row_t next_row;
    if (!rst_n) begin
      in_valid      <= 1'b0;
      row           <= '0;
      column_levels <= '0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        predict_tone_events(row, column_levels);
        rows_accepted <= rows_accepted + 1;
      end
      if ($urandom_range(0, 63) == 0) begin
        in_calm <= ~in_calm;
      end
      if (!in_valid || accepted) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (scan_rows_pending.size() > 0) begin
          next_row      = scan_rows_pending.pop_front();
          row           <= next_row.row;
          column_levels <= next_row.levels;
          in_valid      <= 1'b1;
          in_gap        <= pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted output transaction is checked field by field
  // against the oldest predicted event. Ready is withdrawn at random, and for
  // the whole of the hold-off stretch.
  int unsigned out_gap  = 0;
  logic        out_calm = 1'b0;

  always @(posedge clk or negedge rst_n) begin
    tone_event_t want;
    int unsigned gap;
    int unsigned errs;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      errs = 0;
      if (out_valid && out_ready) begin
        if (tone_events_due.size() == 0) begin
          $error("tone event with none expected: key_index %0d tone_on %0d freq %0d last %0d",
                 key_index, tone_on, frequency_hz, last);
          errs++;
        end else begin
          want = tone_events_due.pop_front();
          if (key_index !== want.key_index) begin
            $error("key_index: expected %0d, actual %0d", want.key_index, key_index);
            errs++;
          end
          if (tone_on !== want.tone_on) begin
            $error("tone_on: expected %0d, actual %0d", want.tone_on, tone_on);
            errs++;
          end
          if (frequency_hz !== want.frequency_hz) begin
            $error("frequency_hz: expected %0d, actual %0d", want.frequency_hz, frequency_hz);
            errs++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        mismatch_count <= mismatch_count + errs;
      end
      if ($urandom_range(0, 63) == 0) begin
        out_calm <= ~out_calm;
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        gap = pick_gap(out_calm);
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_gap   <= gap - 1;
          out_ready <= 1'b0;
        end
      end
    end
  end

  // Once the run is well under way the receiver stops for a long stretch while
  // the driver keeps offering rows, so the output register fills and the block
  // must hold off its input.
  initial begin
    wait (rows_accepted >= HOLD_OFF_AFTER_ROWS);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    int unsigned                   changing_rows;
    int unsigned                   rows_total;
    int unsigned                   r;
    logic [kmct_pkg::ROW_W-1:0]    scan_row;
    logic [kmct_pkg::LEVELS_W-1:0] cur;
    logic [kmct_pkg::LEVELS_W-1:0] mask;
    logic                          changed;

    for (int unsigned i = 0; i < MATRIX_ROWS; i++) begin
      gen_row_levels[i] = '1;
    end

    // Directed part. Pressing a whole row and releasing it gives the longest
    // bursts of eight events; an unchanged row must give nothing; single keys at
    // both ends of the matrix check the lowest and highest notes.
    void'(queue_scan_row(2'd0, 8'h00));
    void'(queue_scan_row(2'd0, 8'h00));
    void'(queue_scan_row(2'd0, 8'hFF));
    void'(queue_scan_row(2'd3, 8'h7F));
    void'(queue_scan_row(2'd3, 8'hFF));
    void'(queue_scan_row(2'd0, 8'hFE));
    void'(queue_scan_row(2'd0, 8'hFF));
    void'(queue_scan_row(2'd1, 8'h55));
    void'(queue_scan_row(2'd1, 8'hAA));
    void'(queue_scan_row(2'd1, 8'hFF));
    void'(queue_scan_row(2'd2, 8'h00));
    void'(queue_scan_row(2'd3, 8'h00));
    void'(queue_scan_row(2'd2, 8'hFF));
    void'(queue_scan_row(2'd3, 8'hFF));
    void'(queue_scan_row(2'd1, 8'hFF));
    void'(queue_scan_row(2'd2, 8'hEF));
    void'(queue_scan_row(2'd2, 8'hE7));
    void'(queue_scan_row(2'd2, 8'hF7));
    void'(queue_scan_row(2'd2, 8'hFF));
    void'(queue_scan_row(2'd0, 8'h80));

    // Random part, modelled on real playing: mostly one or two keys going
    // down or up at a time, with some chords, whole-row slams and arbitrary
    // patterns, and a sprinkling of scans in which nothing changed.
    changing_rows = 0;
    while (changing_rows < RANDOM_CHANGING_ROWS) begin
      r        = $urandom_range(0, 99);
      scan_row = kmct_pkg::ROW_W'($urandom_range(0, MATRIX_ROWS - 1));
      cur      = gen_row_levels[scan_row];
      if (r < 50) begin
        mask = 8'h01 << $urandom_range(0, MATRIX_COLS - 1);
      end else if (r < 70) begin
        mask = (8'h01 << $urandom_range(0, MATRIX_COLS - 1)) |
               (8'h01 << $urandom_range(0, MATRIX_COLS - 1)) |
               (8'h01 << $urandom_range(0, MATRIX_COLS - 1));
      end else if (r < 84) begin
        mask = cur ^ 8'($urandom_range(0, 255));
      end else if (r < 92) begin
        mask = cur ^ (($urandom_range(0, 1) == 1) ? 8'h00 : 8'hFF);
      end else begin
        mask = 8'h00;
      end
      changed = queue_scan_row(scan_row, cur ^ mask);
      if (changed) begin
        changing_rows++;
      end
    end
    rows_total = scan_rows_pending.size();

    // Wait for every row to be taken, then for every predicted event to
    // arrive, then a little longer to catch any stray event.
    wait (rst_n);
    while (rows_accepted < rows_total) begin
      @(posedge clk);
    end
    while (tone_events_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && tone_events_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
